/* src/complex_arithmetic_unit_macros.svh */
// ---------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CAU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define CAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/cau_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Complex arithmetic unit package
// Opcodes, stage counts, pipeline record types and saturation functions.
// ---------------------------------------------------------------------------
package cau_pkg;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_CONJ = 3'd4;
  localparam logic [2:0] OP_MOD  = 3'd5;

  localparam int QF           = 16;
  localparam int FRONT_STAGES = 3;
  localparam int QBITS        = 33;
  localparam int RBITS        = 32;

  localparam logic [63:0] RND_HALF     = 64'h0000_0000_0000_8000;
  localparam logic [47:0] DIV_SAT_MAG  = 48'h0100_0000_0000;
  localparam logic [31:0] Q_MAX        = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN        = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] val;
    logic        ov;
  } cau_sat_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] smp_re;
    logic [31:0] smp_im;
    logic        smp_ov;
    logic        neg_re;
    logic [63:0] mag_re;
    logic        neg_im;
    logic [63:0] mag_im;
    logic [63:0] den;
  } cau_s3_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] re;
    logic [31:0] im;
    logic        ov;
    logic        dz;
    logic        sat_re;
    logic        sat_im;
    logic        neg_re;
    logic        neg_im;
  } cau_side_t;

  function automatic cau_sat_t sat_sm(input logic neg, input logic [47:0] mag);
    cau_sat_t r;
    r.ov = 1'b0;
    if (!neg) begin
      if (mag > {16'd0, Q_MAX}) begin
        r.val = Q_MAX;
        r.ov  = 1'b1;
      end else begin
        r.val = mag[31:0];
      end
    end else begin
      if (mag > {16'd0, Q_MIN}) begin
        r.val = Q_MIN;
        r.ov  = 1'b1;
      end else begin
        r.val = 32'd0 - mag[31:0];
      end
    end
    return r;
  endfunction

  function automatic cau_sat_t sat33(input logic [32:0] s);
    cau_sat_t r;
    r.ov  = s[32] ^ s[31];
    r.val = r.ov ? (s[32] ? Q_MIN : Q_MAX) : s[31:0];
    return r;
  endfunction

endpackage

/* src/cau_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Complex arithmetic unit channels
// Operand and result channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface cau_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        cmd;
  logic signed [31:0] a_real;
  logic signed [31:0] a_imag;
  logic signed [31:0] b_real;
  logic signed [31:0] b_imag;
  modport source (output valid, cmd, a_real, a_imag, b_real, b_imag, input ready);
  modport sink (input valid, cmd, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_real;
  logic signed [31:0] res_imag;
  logic               overflow;
  logic               divide_by_zero;
  modport source (output valid, res_real, res_imag, overflow, divide_by_zero, input ready);
  modport sink (input valid, res_real, res_imag, overflow, divide_by_zero, output ready);
endinterface

/* src/complex_arithmetic_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Complex arithmetic unit
// Pipelined complex ALU on Q16.16 operands: add, subtract, multiply,
// divide, conjugate and modulus, with saturation and divide-by-zero flag.
// ---------------------------------------------------------------------------
// Channel | Direction | Payload
// in_ch   | sink      | cmd, a_real, a_imag, b_real, b_imag
// out_ch  | source    | res_real, res_imag, overflow, divide_by_zero
//
// One beat is accepted every cycle unless a full output register waits to be taken;
// each beat passes through the 33-stage divider and root pipelines.
// Reset is synchronous and active low and clears only the valid bits.
// A full output register that is not taken freezes every stage at once,
// so nothing is dropped or repeated.
// ---------------------------------------------------------------------------
`include "complex_arithmetic_unit_macros.svh"

module complex_arithmetic_unit import cau_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  cau_in_if.sink    in_ch,
  cau_out_if.source out_ch
);

  localparam int PIPE_LEN = FRONT_STAGES + QBITS;
  localparam int LAST     = QBITS - 1;

  logic                adv;
  logic [PIPE_LEN-1:0] vld_r, vld_nxt;
  logic                out_valid_r;
  cau_s3_t             s3;
  cau_side_t           side0, sd;
  cau_side_t           side_r [0:QBITS-1];
  logic [QBITS-1:0]    quo_re, quo_im;
  logic [RBITS:0]      root;
  logic [63:0]         rnd_re, rnd_im;
  cau_sat_t            mr_re, mr_im, dv_re, dv_im, md;
  logic [QBITS:0]      qr_re, qr_im;
  logic [47:0]         dm_re, dm_im;
  logic [31:0]         res_re_r, res_im_r, res_re_nxt, res_im_nxt;
  logic                ov_r, dz_r, ov_nxt, dz_nxt;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign vld_nxt     = {vld_r[PIPE_LEN-2:0], in_ch.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[PIPE_LEN-1];
    end
  end

  cau_front u_front (
    .clk    (clk),
    .en     (adv),
    .cmd    (in_ch.cmd),
    .a_real (in_ch.a_real),
    .a_imag (in_ch.a_imag),
    .b_real (in_ch.b_real),
    .b_imag (in_ch.b_imag),
    .s3     (s3)
  );

  assign rnd_re = s3.mag_re + RND_HALF;
  assign rnd_im = s3.mag_im + RND_HALF;
  assign mr_re  = sat_sm(s3.neg_re, rnd_re[63:QF]);
  assign mr_im  = sat_sm(s3.neg_im, rnd_im[63:QF]);

  always_comb begin
    side0.cmd    = s3.cmd;
    side0.dz     = (s3.den == '0);
    side0.sat_re = {{QF{1'b0}}, s3.mag_re[63:QF]} >= s3.den;
    side0.sat_im = {{QF{1'b0}}, s3.mag_im[63:QF]} >= s3.den;
    side0.neg_re = s3.neg_re;
    side0.neg_im = s3.neg_im;
    if (s3.cmd == OP_MUL) begin
      side0.re = mr_re.val;
      side0.im = mr_im.val;
      side0.ov = mr_re.ov | mr_im.ov;
    end else begin
      side0.re = s3.smp_re;
      side0.im = s3.smp_im;
      side0.ov = s3.smp_ov;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= side0;
      for (int i = 1; i < QBITS; i++) side_r[i] <= side_r[i-1];
    end
  end

  cau_div u_div_re (
    .clk (clk),
    .en  (adv),
    .num (s3.mag_re),
    .den (s3.den),
    .quo (quo_re)
  );

  cau_div u_div_im (
    .clk (clk),
    .en  (adv),
    .num (s3.mag_im),
    .den (s3.den),
    .quo (quo_im)
  );

  cau_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .sq   (s3.den),
    .root (root)
  );

  assign sd    = side_r[LAST];
  assign qr_re = {1'b0, quo_re} + {{QBITS{1'b0}}, 1'b1};
  assign qr_im = {1'b0, quo_im} + {{QBITS{1'b0}}, 1'b1};
  assign dm_re = sd.sat_re ? DIV_SAT_MAG : {{(48-QBITS){1'b0}}, qr_re[QBITS:1]};
  assign dm_im = sd.sat_im ? DIV_SAT_MAG : {{(48-QBITS){1'b0}}, qr_im[QBITS:1]};
  assign dv_re = sat_sm(sd.neg_re, dm_re);
  assign dv_im = sat_sm(sd.neg_im, dm_im);
  assign md    = sat_sm(1'b0, {{(47-RBITS){1'b0}}, root});

  always_comb begin
    case (sd.cmd)
      OP_DIV: begin
        if (sd.dz) begin
          res_re_nxt = '0;
          res_im_nxt = '0;
          ov_nxt     = 1'b0;
          dz_nxt     = 1'b1;
        end else begin
          res_re_nxt = dv_re.val;
          res_im_nxt = dv_im.val;
          ov_nxt     = dv_re.ov | dv_im.ov;
          dz_nxt     = 1'b0;
        end
      end
      OP_MOD: begin
        res_re_nxt = md.val;
        res_im_nxt = '0;
        ov_nxt     = md.ov;
        dz_nxt     = 1'b0;
      end
      default: begin
        res_re_nxt = sd.re;
        res_im_nxt = sd.im;
        ov_nxt     = sd.ov;
        dz_nxt     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      ov_r     <= ov_nxt;
      dz_r     <= dz_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.res_real       = res_re_r;
  assign out_ch.res_imag       = res_im_r;
  assign out_ch.overflow       = ov_r;
  assign out_ch.divide_by_zero = dz_r;

  `CAU_ASSERT_SAME(a_dz_zero, clk, rst_n, out_valid_r && dz_r, res_re_r == '0 && res_im_r == '0 && !ov_r, "Divide by zero beat carries a non-zero result.")
  `CAU_ASSERT_NEXT(a_stall_hold, clk, rst_n, !adv, $stable(vld_r) && $stable(res_re_r), "Pipeline moved during a stall.")
  `CAU_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_ch.valid && in_ch.ready, vld_r[0], "Accepted beat did not enter the first stage.")
  `CAU_ASSERT_NEXT(a_mod_imag, clk, rst_n, adv && vld_r[PIPE_LEN-1] && side_r[LAST].cmd == OP_MOD, out_valid_r && res_im_r == '0 && !dz_r, "Modulus beat has a non-zero imaginary part.")

endmodule

/* src/cau_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Complex arithmetic unit front end
// Three stages: products, cross sums, sign and magnitude split.
// ---------------------------------------------------------------------------
module cau_front import cau_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [2:0]  cmd,
  input  logic [31:0] a_real,
  input  logic [31:0] a_imag,
  input  logic [31:0] b_real,
  input  logic [31:0] b_imag,
  output cau_s3_t     s3
);

  logic signed [31:0] ar_s, ai_s, br_s, bi_s, x4_s, x5_s;
  logic [32:0]        sum_re, sum_im;
  cau_sat_t           smp_re, smp_im;

  logic [2:0]         cmd1_r, cmd2_r;
  logic signed [63:0] p_r [0:5];
  logic signed [63:0] p_nxt [0:5];
  logic [31:0]        sre1_r, sim1_r, sre2_r, sim2_r;
  logic               sov1_r, sov2_r;
  logic [64:0]        e0, e1, e2, e3, re_nxt, im_nxt, re_r, im_r, nre, nim;
  logic [63:0]        den_nxt, den_r;
  cau_s3_t            s3_r, s3_nxt;

  assign ar_s = a_real;
  assign ai_s = a_imag;
  assign br_s = b_real;
  assign bi_s = b_imag;
  assign x4_s = (cmd == OP_MOD) ? ar_s : br_s;
  assign x5_s = (cmd == OP_MOD) ? ai_s : bi_s;

  assign p_nxt[0] = ar_s * br_s;
  assign p_nxt[1] = ai_s * bi_s;
  assign p_nxt[2] = ar_s * bi_s;
  assign p_nxt[3] = ai_s * br_s;
  assign p_nxt[4] = x4_s * x4_s;
  assign p_nxt[5] = x5_s * x5_s;

  always_comb begin
    sum_re = 33'd0;
    sum_im = 33'd0;
    case (cmd)
      OP_ADD: begin
        sum_re = {a_real[31], a_real} + {b_real[31], b_real};
        sum_im = {a_imag[31], a_imag} + {b_imag[31], b_imag};
      end
      OP_SUB: begin
        sum_re = {a_real[31], a_real} - {b_real[31], b_real};
        sum_im = {a_imag[31], a_imag} - {b_imag[31], b_imag};
      end
      OP_CONJ: begin
        sum_re = {a_real[31], a_real};
        sum_im = 33'd0 - {a_imag[31], a_imag};
      end
      default: begin
        sum_re = 33'd0;
        sum_im = 33'd0;
      end
    endcase
    smp_re = sat33(sum_re);
    smp_im = sat33(sum_im);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r <= cmd;
      for (int i = 0; i < 6; i++) p_r[i] <= p_nxt[i];
      sre1_r <= smp_re.val;
      sim1_r <= smp_im.val;
      sov1_r <= smp_re.ov | smp_im.ov;
    end
  end

  assign e0 = {p_r[0][63], p_r[0]};
  assign e1 = {p_r[1][63], p_r[1]};
  assign e2 = {p_r[2][63], p_r[2]};
  assign e3 = {p_r[3][63], p_r[3]};
  assign re_nxt  = (cmd1_r == OP_MUL) ? e0 - e1 : e0 + e1;
  assign im_nxt  = (cmd1_r == OP_MUL) ? e2 + e3 : e3 - e2;
  assign den_nxt = p_r[4] + p_r[5];

  always_ff @(posedge clk) begin
    if (en) begin
      cmd2_r <= cmd1_r;
      sre2_r <= sre1_r;
      sim2_r <= sim1_r;
      sov2_r <= sov1_r;
      re_r   <= re_nxt;
      im_r   <= im_nxt;
      den_r  <= den_nxt;
    end
  end

  assign nre = 65'd0 - re_r;
  assign nim = 65'd0 - im_r;

  always_comb begin
    s3_nxt.cmd    = cmd2_r;
    s3_nxt.smp_re = sre2_r;
    s3_nxt.smp_im = sim2_r;
    s3_nxt.smp_ov = sov2_r;
    s3_nxt.neg_re = re_r[64];
    s3_nxt.mag_re = re_r[64] ? nre[63:0] : re_r[63:0];
    s3_nxt.neg_im = im_r[64];
    s3_nxt.mag_im = im_r[64] ? nim[63:0] : im_r[63:0];
    s3_nxt.den    = den_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= s3_nxt;
    end
  end

  assign s3 = s3_r;

endmodule

/* src/cau_div.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Complex arithmetic unit divider
// Pipelined restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module cau_div import cau_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [63:0]      num,
  input  logic [63:0]      den,
  output logic [QBITS-1:0] quo
);

  logic [63:0]      rem_r [0:QBITS-2];
  logic [63:0]      den_r [0:QBITS-2];
  logic [QF-1:0]    low_r [0:QBITS-2];
  logic [QBITS-1:0] quo_r [0:QBITS-1];

  for (genvar g = 0; g < QBITS; g++) begin : g_stage
    logic [63:0]      rem_i, den_i;
    logic [QF-1:0]    low_i;
    logic [QBITS-1:0] quo_i;
    logic [64:0]      rw, diff;
    logic             ge;

    if (g == 0) begin : g_first
      assign rem_i = {{QF{1'b0}}, num[63:QF]};
      assign den_i = den;
      assign low_i = num[QF-1:0];
      assign quo_i = '0;
    end else begin : g_next
      assign rem_i = rem_r[g-1];
      assign den_i = den_r[g-1];
      assign low_i = low_r[g-1];
      assign quo_i = quo_r[g-1];
    end

    assign rw   = {rem_i, low_i[QF-1]};
    assign ge   = rw >= {1'b0, den_i};
    assign diff = rw - {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[g] <= {quo_i[QBITS-2:0], ge};
      end
    end

    if (g < QBITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[g] <= ge ? diff[63:0] : rw[63:0];
          den_r[g] <= den_i;
          low_r[g] <= {low_i[QF-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = quo_r[QBITS-1];

endmodule

/* src/cau_sqrt.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Complex arithmetic unit square root
// Pipelined digit-by-digit root, one bit per stage, then a rounding stage.
// ---------------------------------------------------------------------------
module cau_sqrt import cau_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [63:0]    sq,
  output logic [RBITS:0] root
);

  logic [RBITS+2:0] rem_r  [0:RBITS-1];
  logic [RBITS-1:0] root_r [0:RBITS-1];
  logic [63:0]      sv_r   [0:RBITS-2];
  logic [RBITS:0]   out_r;

  for (genvar g = 0; g < RBITS; g++) begin : g_stage
    logic [RBITS+2:0] rem_i, remw, trial;
    logic [RBITS-1:0] root_i;
    logic [63:0]      sv_i;
    logic             ge;

    if (g == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign sv_i   = sq;
    end else begin : g_next
      assign rem_i  = rem_r[g-1];
      assign root_i = root_r[g-1];
      assign sv_i   = sv_r[g-1];
    end

    assign remw  = {rem_i[RBITS:0], sv_i[63:62]};
    assign trial = {1'b0, root_i, 2'b01};
    assign ge    = remw >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= ge ? remw - trial : remw;
        root_r[g] <= {root_i[RBITS-2:0], ge};
      end
    end

    if (g < RBITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          sv_r[g] <= {sv_i[61:0], 2'b00};
        end
      end
    end
  end

  // Round to nearest: step up when the remainder exceeds the root.
  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= {1'b0, root_r[RBITS-1]} +
               {{RBITS{1'b0}}, (rem_r[RBITS-1] > {3'b000, root_r[RBITS-1]})};
    end
  end

  assign root = out_r;

endmodule

/* verif/tb_complex_arithmetic_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives operand beats through the valid/ready channel with random gaps,
// stalls the result channel at random and checks every result against an
// in-bench model of the Q16.16 add, subtract, multiply, divide, conjugate
// and modulus operations, including saturation and divide by zero.
// ---------------------------------------------------------------------------
module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [31:0] Q_ONE      = 32'h0001_0000;
  localparam int STALL_LIMIT         = 4000;
  localparam int DRAIN_CYCLES        = 60;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        ov;
    logic        dz;
  } cplx_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cau_in_if  in_bus ();
  cau_out_if out_bus ();

  complex_arithmetic_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always #6 clk = ~clk;

  cplx_res_t expected_results[$];
  int        error_count = 0;
  int        result_count = 0;
  int        sent_count = 0;
  int        op_seen[8];
  logic      busy_mode = 1'b0;

  initial begin
    in_bus.valid  = 1'b0;
    in_bus.cmd    = '0;
    in_bus.a_real = '0;
    in_bus.a_imag = '0;
    in_bus.b_real = '0;
    in_bus.b_imag = '0;
    out_bus.ready = 1'b0;
  end

  function automatic logic [31:0] clamp_q(input logic signed [71:0] v, inout logic ov);
    if (v > 72'sh7fff_ffff) begin
      ov = 1'b1;
      return Q_MAX;
    end
    if (v < -72'sh8000_0000) begin
      ov = 1'b1;
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [71:0] round_mul(input logic signed [71:0] s);
    logic [71:0] mag;
    logic [71:0] r;
    mag = s < 0 ? -s : s;
    r = (mag + 72'h8000) >> QF;
    return s < 0 ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [71:0] round_div(input logic signed [71:0] s,
                                                   input logic [71:0] den);
    logic [127:0] mag;
    logic [127:0] q;
    mag = s < 0 ? -s : s;
    q = mag / den;
    if (q >= 128'h1_0000) q = 128'h100_0000_0000;
    else q = (((mag << (QF + 1)) / den) + 1) >> 1;
    return s < 0 ? -$signed(q[71:0]) : $signed(q[71:0]);
  endfunction

  function automatic logic [63:0] root_round(input logic [63:0] s);
    logic [63:0] acc;
    logic [63:0] bitv;
    acc = '0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= acc + bitv) begin
        s = s - (acc + bitv);
        acc = (acc >> 1) + bitv;
      end else begin
        acc = acc >> 1;
      end
      bitv = bitv >> 2;
    end
    if (s > acc) acc = acc + 1;
    return acc;
  endfunction

  function automatic cplx_res_t complex_result(input logic [2:0] op,
      input logic [31:0] ar_i, input logic [31:0] ai_i,
      input logic [31:0] br_i, input logic [31:0] bi_i);
    cplx_res_t r;
    logic signed [71:0] ar, ai, br, bi;
    logic [71:0] den;
    logic ov;
    ar = $signed(ar_i);
    ai = $signed(ai_i);
    br = $signed(br_i);
    bi = $signed(bi_i);
    ov = 1'b0;
    r = '0;
    case (op)
      OP_ADD: begin
        r.re = clamp_q(ar + br, ov);
        r.im = clamp_q(ai + bi, ov);
      end
      OP_SUB: begin
        r.re = clamp_q(ar - br, ov);
        r.im = clamp_q(ai - bi, ov);
      end
      OP_MUL: begin
        r.re = clamp_q(round_mul(ar * br - ai * bi), ov);
        r.im = clamp_q(round_mul(ar * bi + ai * br), ov);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          r.re = clamp_q(round_div(ar * br + ai * bi, den), ov);
          r.im = clamp_q(round_div(ai * br - ar * bi, den), ov);
        end
      end
      OP_CONJ: begin
        r.re = clamp_q(ar, ov);
        r.im = clamp_q(-ai, ov);
      end
      OP_MOD: begin
        den = ar * ar + ai * ai;
        r.re = clamp_q($signed({8'd0, root_round(den[63:0])}), ov);
      end
      default: ;
    endcase
    r.ov = ov;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got %h expected %h", result_count, what, got, want);
    error_count++;
  endtask

  // Each beat: draw a gap, then hold valid until the block takes the operands.
  task automatic send_operands(input logic [2:0] op, input logic [31:0] ar,
      input logic [31:0] ai, input logic [31:0] br, input logic [31:0] bi);
    int gap;
    gap = busy_mode ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid  <= 1'b1;
    in_bus.cmd    <= op;
    in_bus.a_real <= ar;
    in_bus.a_imag <= ai;
    in_bus.b_real <= br;
    in_bus.b_imag <= bi;
    do @(posedge clk); while (!in_bus.ready);
    expected_results.push_back(complex_result(op, ar, ai, br, bi));
    op_seen[op]++;
    sent_count++;
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side: random stall per beat, with stretches of none.
  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      stall = busy_mode ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  always @(posedge clk) begin
    cplx_res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", out_bus.res_real, 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_bus.res_real !== want.re) report_mismatch("res_real", out_bus.res_real, want.re);
        if (out_bus.res_imag !== want.im) report_mismatch("res_imag", out_bus.res_imag, want.im);
        if (out_bus.overflow !== want.ov)
          report_mismatch("overflow", {31'd0, out_bus.overflow}, {31'd0, want.ov});
        if (out_bus.divide_by_zero !== want.dz)
          report_mismatch("divide_by_zero", {31'd0, out_bus.divide_by_zero}, {31'd0, want.dz});
      end
      result_count++;
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_operand();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: begin
        case ($urandom_range(0, 4))
          0: return Q_MIN;
          1: return Q_MAX;
          2: return 32'd0;
          3: return Q_ONE;
          default: return 32'hffff_ffff;
        endcase
      end
      1, 2, 3: return $urandom_range(0, 1) ? $urandom_range(0, 32'h3_ffff)
                                            : -$urandom_range(0, 32'h3_ffff);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_add_sub();
    send_operands(OP_ADD, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    send_operands(OP_ADD, Q_MAX, 32'hffff_ffff, Q_MIN, 32'd1);
    send_operands(OP_ADD, Q_ONE, 32'd0, Q_ONE, 32'd0);
    send_operands(OP_SUB, Q_MIN, Q_MAX, 32'd1, 32'hffff_ffff);
    send_operands(OP_SUB, Q_MAX, Q_MIN, Q_MIN, Q_MAX);
    send_operands(OP_SUB, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000);
  endtask

  task automatic test_multiply();
    send_operands(OP_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_operands(OP_MUL, Q_MIN, Q_MAX, Q_MAX, Q_MIN);
    send_operands(OP_MUL, 32'h0000_8000, 32'd0, 32'd1, 32'd0);
    send_operands(OP_MUL, 32'hffff_8000, 32'd0, 32'd1, 32'd0);
    send_operands(OP_MUL, Q_ONE, Q_ONE, Q_ONE, 32'hffff_0000);
  endtask

  task automatic test_divide();
    send_operands(OP_DIV, Q_ONE, Q_ONE, 32'd0, 32'd0);
    send_operands(OP_DIV, Q_MAX, Q_MIN, 32'd0, 32'd0);
    send_operands(OP_DIV, Q_MAX, Q_MAX, 32'd1, 32'd0);
    send_operands(OP_DIV, Q_ONE, 32'd0, 32'h0003_0000, 32'd0);
    send_operands(OP_DIV, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_operands(OP_DIV, 32'd1, 32'd0, Q_MAX, Q_MAX);
  endtask

  task automatic test_conj_mod();
    send_operands(OP_CONJ, Q_MIN, Q_MIN, Q_MAX, Q_MAX);
    send_operands(OP_CONJ, Q_MAX, Q_MAX, 32'd0, 32'd0);
    send_operands(OP_MOD, Q_MIN, Q_MIN, 32'd0, 32'd0);
    send_operands(OP_MOD, 32'h0003_0000, 32'h0004_0000, Q_MIN, Q_MAX);
    send_operands(OP_MOD, 32'd0, 32'd0, 32'd0, 32'd0);
    send_operands(OP_MOD, 32'd1, 32'd1, 32'd0, 32'd0);
  endtask

  task automatic test_spare_opcodes();
    send_operands(OP_SPARE_LO, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    send_operands(OP_SPARE_HI, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_random(input int count);
    logic [2:0]  op;
    logic [31:0] br;
    logic [31:0] bi;
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) busy_mode = ($urandom_range(0, 2) == 0);
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      br = pick_operand();
      bi = pick_operand();
      if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
        br = '0;
        bi = '0;
      end
      send_operands(op, pick_operand(), pick_operand(), br, bi);
      if (i == count / 2) drain_results();
    end
    busy_mode = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_add_sub();
    test_multiply();
    test_divide();
    test_conj_mod();
    test_spare_opcodes();
    drain_results();
    test_random(1000);
    drain_results();
    $display("covered %0d operand beats and %0d results: add %0d sub %0d mul %0d div %0d",
             sent_count, result_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("conjugate %0d, modulus %0d, spare opcodes %0d, with random gaps and stalls",
             op_seen[4], op_seen[5], op_seen[6] + op_seen[7]);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/cau_pkg.sv
src/cau_if.sv
src/cau_front.sv
src/cau_div.sv
src/cau_sqrt.sv
src/complex_arithmetic_unit.sv
verif/tb_complex_arithmetic_unit.sv
